// ===== rtl/jkmd_pkg.sv =====
// ----------------------------------------------------------------------------
// jkmd_pkg
// shared codes and word types for the jog key motor direction control
// ----------------------------------------------------------------------------
package jkmd_pkg;

    localparam logic [1:0] MOTOR_STOP = 2'd0;
    localparam logic [1:0] MOTOR_UP   = 2'd1;
    localparam logic [1:0] MOTOR_DOWN = 2'd2;

    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned OUT_TDATA_W = 8;

    typedef struct packed {
        logic lower_limit_set;
        logic upper_limit_set;
        logic right_rod_hit;
        logic left_rod_hit;
        logic down_key_level;
        logic up_key_level;
    } in_word_t;

    typedef struct packed {
        logic       down_held;
        logic       up_held;
        logic       start_strobe;
        logic       stop_strobe;
        logic [1:0] motor_direction;
    } out_word_t;

endpackage

// ===== rtl/jkmd_core.sv =====
// ----------------------------------------------------------------------------
// jkmd_core
// key debouncers, limit flags and direction state; one scan tick per accept
// ----------------------------------------------------------------------------
module jkmd_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_wdata,
    input  logic               tick,
    input  jkmd_pkg::in_word_t in_word,
    output jkmd_pkg::out_word_t result
);
    import jkmd_pkg::*;

    localparam logic [1:0] PH_IDLE      = 2'd0;
    localparam logic [1:0] PH_DEBOUNCE  = 2'd1;
    localparam logic [1:0] PH_CONFIRMED = 2'd2;

    logic       press_level_reg;
    logic [1:0] phase_reg [2];
    logic [1:0] phase_next [2];
    logic [1:0] hold_reg;
    logic [1:0] hold_next;
    logic [1:0] dir_reg;
    logic [1:0] dir_next;
    logic       upper_flag_reg;
    logic       upper_flag_next;
    logic       lower_flag_reg;
    logic       lower_flag_next;
    logic [1:0] pressed;
    logic       rod;
    logic       up;
    logic       dn;
    logic       stop;
    logic       start;

    assign pressed[0] = (in_word.up_key_level == press_level_reg);
    assign pressed[1] = (in_word.down_key_level == press_level_reg);
    assign rod        = in_word.left_rod_hit | in_word.right_rod_hit;

    // three-phase debouncer per key
    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            phase_next[k] = phase_reg[k];
            hold_next[k]  = hold_reg[k];
            unique case (phase_reg[k])
                PH_DEBOUNCE:
                begin
                    if (pressed[k])
                    begin
                        hold_next[k]  = 1'b1;
                        phase_next[k] = PH_CONFIRMED;
                    end
                    else
                    begin
                        phase_next[k] = PH_IDLE;
                    end
                end
                PH_CONFIRMED:
                begin
                    if (!pressed[k])
                    begin
                        hold_next[k]  = 1'b0;
                        phase_next[k] = PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next[k] = pressed[k] ? PH_DEBOUNCE : PH_IDLE;
                end
            endcase
        end
    end

    assign up = hold_next[0];
    assign dn = hold_next[1];

    // release-stop, conflict-stop, then start
    always_comb
    begin
        dir_next        = dir_reg;
        stop            = 1'b0;
        start           = 1'b0;
        upper_flag_next = upper_flag_reg | in_word.upper_limit_set;
        lower_flag_next = lower_flag_reg | in_word.lower_limit_set;

        if ((!up && dir_next == MOTOR_UP) || (!dn && dir_next == MOTOR_DOWN))
        begin
            dir_next = MOTOR_STOP;
            stop     = 1'b1;
        end
        if (up && dn && dir_next != MOTOR_STOP)
        begin
            dir_next = MOTOR_STOP;
            stop     = 1'b1;
        end
        if (dir_next == MOTOR_STOP)
        begin
            priority if (up && !dn)
            begin
                if (!upper_flag_next)
                begin
                    dir_next        = MOTOR_UP;
                    lower_flag_next = 1'b0;
                    start           = 1'b1;
                end
            end
            else if (dn && !up)
            begin
                if (!lower_flag_next)
                begin
                    dir_next        = MOTOR_DOWN;
                    upper_flag_next = 1'b0;
                    start           = 1'b1;
                end
            end
            else if (up && dn)
            begin
                // forced descent ignores the lower limit, rods block it
                if (!rod)
                begin
                    dir_next        = MOTOR_DOWN;
                    lower_flag_next = 1'b0;
                    start           = 1'b1;
                end
            end
            else
            begin
                start = 1'b0;
            end
        end
    end

    assign result.motor_direction = dir_next;
    assign result.stop_strobe     = stop;
    assign result.start_strobe    = start;
    assign result.up_held         = hold_next[0];
    assign result.down_held       = hold_next[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_level_reg <= 1'b0;
            phase_reg[0]    <= PH_IDLE;
            phase_reg[1]    <= PH_IDLE;
            hold_reg        <= 2'b00;
            dir_reg         <= MOTOR_STOP;
            upper_flag_reg  <= 1'b0;
            lower_flag_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                press_level_reg <= cfg_wdata;
            end
            if (tick)
            begin
                phase_reg[0]   <= phase_next[0];
                phase_reg[1]   <= phase_next[1];
                hold_reg       <= hold_next;
                dir_reg        <= dir_next;
                upper_flag_reg <= upper_flag_next;
                lower_flag_reg <= lower_flag_next;
            end
        end
    end

endmodule

// ===== rtl/jog_key_motor_direction_control.sv =====
// ----------------------------------------------------------------------------
// jog_key_motor_direction_control
// two-key jog control with debounce, limit flags and motor direction
// ----------------------------------------------------------------------------
//  channel   dir  fields (lsb first)
//  s_axis    in   up_key_level, down_key_level, left_rod_hit, right_rod_hit,
//                 upper_limit_set, lower_limit_set
//  m_axis    out  motor_direction[1:0], stop_strobe, start_strobe, up_held,
//                 down_held
//  cfg       in   press_level (cfg_wdata, written when cfg_we is high)
//
//  one result word per input word, one per clock while m_axis_tready is high
//  a word's state update and result are settled in the cycle it is accepted;
//  the result is then registered in the output register or the skid stage
//  output register plus skid stage: input stalls only when both are full
//  reset clears the key state, limit flags, direction and press level
module jog_key_motor_direction_control
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic                                cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // up_key_level, down_key_level, left_rod_hit, right_rod_hit,
    // upper_limit_set, lower_limit_set, zero pad
    input  logic [jkmd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // motor_direction[1:0], stop_strobe, start_strobe, up_held, down_held,
    // zero pad
    output logic [jkmd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import jkmd_pkg::*;

    localparam int unsigned OUT_PAD = OUT_TDATA_W - $bits(out_word_t);

    in_word_t  in_word;
    out_word_t result;
    logic      accept;
    logic      take;
    logic      out_valid_reg;
    logic      out_valid_next;
    out_word_t out_word_reg;
    logic      skid_valid_reg;
    logic      skid_valid_next;
    out_word_t skid_word_reg;

    assign in_word       = in_word_t'(s_axis_tdata[$bits(in_word_t)-1:0]);
    assign s_axis_tready = !skid_valid_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign take          = out_valid_reg && m_axis_tready;

    jkmd_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .tick      (accept),
        .in_word   (in_word),
        .result    (result)
    );

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (take)
        begin
            out_valid_next  = skid_valid_reg || accept;
            skid_valid_next = 1'b0;
        end
        else if (accept)
        begin
            out_valid_next  = 1'b1;
            skid_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_word_reg <= skid_valid_reg ? skid_word_reg : result;
        end
        else if (accept && !out_valid_reg)
        begin
            out_word_reg <= result;
        end
        if (accept && out_valid_reg && !take)
        begin
            skid_word_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{OUT_PAD{1'b0}}, out_word_reg};

endmodule

// ===== rtl/jkmd_checker.sv =====
// ----------------------------------------------------------------------------
// jkmd_checker
// port-level checks on the result stream, bound to the top level
// ----------------------------------------------------------------------------
module jkmd_checker
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [jkmd_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import jkmd_pkg::*;

    logic [1:0] dir;
    logic       stop;
    logic       start;
    logic       up_held;
    logic       down_held;

    assign dir       = m_axis_tdata[1:0];
    assign stop      = m_axis_tdata[2];
    assign start     = m_axis_tdata[3];
    assign up_held   = m_axis_tdata[4];
    assign down_held = m_axis_tdata[5];

    // stalled word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // a start always leaves the motor running
    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && start |-> dir != MOTOR_STOP)
        else $error("start strobe with motor stopped");

    // a stop with no restart leaves the motor stopped
    a_stop_halts: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && stop && !start |-> dir == MOTOR_STOP)
        else $error("stop strobe without restart left the motor running");

    // the motor runs only while its key is held
    a_up_held: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && dir == MOTOR_UP |-> up_held && !down_held)
        else $error("moving up without the up key alone held");

    a_down_held: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && dir == MOTOR_DOWN |-> down_held)
        else $error("moving down without the down key held");

endmodule

bind jog_key_motor_direction_control jkmd_checker u_jkmd_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
